### rtl/lphs_pkg.sv
// Shared types and constants for the linear-probe hash set.
// Holds the table geometry, opcode and status codes, and the beat structs.
// No dependencies.
package lphs_pkg;

  // Table geometry. The home slot is the key modulo the depth, which is a
  // power of two, so it is the low index bits of the key.
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_WIDTH   = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } lphs_op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } lphs_status_t;

  // One request beat.
  typedef struct packed {
    logic [1:0]           opcode;
    logic [KEY_WIDTH-1:0] key;
  } lphs_req_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] entry_count;
  } lphs_rsp_t;

endpackage

### rtl/lphs_key_ram.sv
// Simple dual-port key memory: one write port, one read port.
// Read data is registered, so it arrives in the cycle after the read enable.
// No dependencies.
module lphs_key_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/linear_probe_hash_set_core.sv
// Top level of the linear-probe hash set.
// Depends on lphs_pkg and lphs_key_ram.
//
// Usage:
//   A request beat (opcode, key) is taken at a rising edge where start is
//   high and busy is low. Exactly one result beat (status, slot,
//   entry_count) follows, shown for one cycle with done high; the receiver
//   must take it in that cycle, since it cannot hold results off.
//   Keys live in a 64-entry memory with one read port and registered read
//   data; the per-slot valid bits and the entry count are flip-flops.
//   Requests that need no probe (opcode 3, insert into a full table,
//   remove or search on an empty table) give their result in the cycle
//   after acceptance. An insert steps past occupied slots from the home
//   slot to the first free one. A remove or search reads each occupied
//   slot from memory, then compares, stopping at a match, an empty slot
//   or a full turn of the table. busy drops in the cycle that done is
//   shown, so the next request can be taken while a result is on the ports.
//   Reset clears the valid bits and the count at once: the table is empty
//   from the first cycle after reset, with no clearing pass.
module linear_probe_hash_set_core
  import lphs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  lphs_req_t request,
  output logic      busy,
  output logic      done,
  output lphs_rsp_t result
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_CMP   = 3'b100
  } state_t;

  state_t               state;
  logic [1:0]           op;
  logic [KEY_WIDTH-1:0] key;
  logic [IDX_W-1:0]     idx;
  logic [CNT_W-1:0]     probes;
  logic [CNT_W-1:0]     count;
  logic [TABLE_DEPTH-1:0] occupied;

  logic                 ram_we;
  logic                 ram_re;
  logic [KEY_WIDTH-1:0] ram_rdata;
  logic                 slot_used;
  logic                 accept;

  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);
  assign slot_used = occupied[idx];

  // Insert writes the key into the first free slot; lookups read the slot.
  assign ram_we = (state == S_PROBE) && (op == OP_INSERT) && !slot_used;
  assign ram_re = (state == S_PROBE) && (op != OP_INSERT) && slot_used;

  lphs_key_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(KEY_WIDTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (key),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Control sequencer, valid bits and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      count    <= '0;
      occupied <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (request.opcode)
              OP_INSERT: begin
                if (count == CNT_W'(TABLE_DEPTH)) begin
                  done <= 1'b1;
                end else begin
                  state <= S_PROBE;
                end
              end
              OP_REMOVE, OP_SEARCH: begin
                if (count == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_PROBE;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_PROBE: begin
          if (op == OP_INSERT) begin
            // Free slot found: claim it. Otherwise step to the next slot.
            if (!slot_used) begin
              occupied[idx] <= 1'b1;
              count         <= count + 1'b1;
              done          <= 1'b1;
              state         <= S_IDLE;
            end
          end else if (!slot_used) begin
            // An empty slot ends the chain without a match.
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (ram_rdata == key) begin
            if (op == OP_REMOVE) begin
              occupied[idx] <= 1'b0;
              count         <= count - 1'b1;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (probes == CNT_W'(TABLE_DEPTH - 1)) begin
            // A full turn of the table without a match.
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_PROBE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture and probe position.
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= request.opcode;
      key    <= request.key;
      idx    <= request.key[IDX_W-1:0];
      probes <= '0;
    end else if (state == S_PROBE && op == OP_INSERT && slot_used) begin
      idx <= idx + 1'b1;
    end else if (state == S_CMP && ram_rdata != key) begin
      idx    <= idx + 1'b1;
      probes <= probes + 1'b1;
    end
  end

  // Result beat; the count reflects this request's own update.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          result.slot        <= '0;
          result.entry_count <= count;
          if (request.opcode == OP_INSERT) begin
            result.status <= ST_FULL;
          end else begin
            result.status <= ST_NOTFOUND;
          end
        end
      end
      S_PROBE: begin
        if (op == OP_INSERT) begin
          if (!slot_used) begin
            result.status      <= ST_OK;
            result.slot        <= idx;
            result.entry_count <= count + 1'b1;
          end
        end else if (!slot_used) begin
          result.status      <= ST_NOTFOUND;
          result.slot        <= '0;
          result.entry_count <= count;
        end
      end
      S_CMP: begin
        result.slot <= '0;
        if (ram_rdata == key) begin
          result.status <= ST_OK;
          if (op == OP_REMOVE) begin
            result.entry_count <= count - 1'b1;
          end else begin
            result.entry_count <= count;
          end
        end else begin
          result.status      <= ST_NOTFOUND;
          result.entry_count <= count;
        end
      end
      default: begin
        result <= result;
      end
    endcase
  end

endmodule

### tb/linear_probe_hash_set_core_test.sv
// Self-checking testbench for linear_probe_hash_set_core.
// Depends on lphs_pkg and the core; it predicts every result beat from its own
// copy of the hash table and compares the beats field by field as they arrive.
`timescale 1ns / 1ps

module linear_probe_hash_set_core_test;
  import lphs_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 1400;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         TAIL_CYCLES  = 2 * TABLE_DEPTH + 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  lphs_req_t request = '0;
  logic      busy;
  logic      done;
  lphs_rsp_t result;

  // Stimulus backlog; a set drain flag makes the sender wait for all results.
  lphs_req_t request_backlog[$];
  bit        drain_before[$];
  // Predicted result beats, oldest first.
  lphs_rsp_t pending_outcomes[$];

  // Predicted table contents.
  logic [KEY_WIDTH-1:0] slot_key [TABLE_DEPTH];
  bit                   slot_used[TABLE_DEPTH];
  int unsigned          used_total = 0;

  int          errors = 0;
  int          items_sent = 0;
  int unsigned cycle_count = 0;

  linear_probe_hash_set_core DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Walks the probe chain from the home slot while slots are occupied.
  // Returns the matching slot, or TABLE_DEPTH when the key is absent.
  function automatic int unsigned locate_key(logic [KEY_WIDTH-1:0] key);
    int unsigned idx;
    int unsigned hit;
    bit          stop;
    idx  = key % TABLE_DEPTH;
    hit  = TABLE_DEPTH;
    stop = 1'b0;
    for (int n = 0; n < TABLE_DEPTH; n++) begin
      if (!stop) begin
        if (!slot_used[idx]) begin
          stop = 1'b1;
        end else if (slot_key[idx] == key) begin
          hit  = idx;
          stop = 1'b1;
        end
        idx = (idx + 1) % TABLE_DEPTH;
      end
    end
    return hit;
  endfunction

  // Applies one request to the predicted table and returns its result beat.
  function automatic lphs_rsp_t apply_request(lphs_req_t req);
    lphs_rsp_t   rsp;
    int unsigned idx;
    bit          placed;
    rsp        = '0;
    rsp.status = ST_NOTFOUND;
    case (req.opcode)
      OP_INSERT: begin
        rsp.status = ST_FULL;
        if (used_total < TABLE_DEPTH) begin
          idx    = req.key % TABLE_DEPTH;
          placed = 1'b0;
          for (int n = 0; n < TABLE_DEPTH; n++) begin
            if (!placed) begin
              if (!slot_used[idx]) begin
                slot_key[idx]  = req.key;
                slot_used[idx] = 1'b1;
                used_total++;
                rsp.status = ST_OK;
                rsp.slot   = idx[IDX_W-1:0];
                placed     = 1'b1;
              end
              idx = (idx + 1) % TABLE_DEPTH;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (used_total != 0) begin
          idx = locate_key(req.key);
          if (idx < TABLE_DEPTH) begin
            slot_used[idx] = 1'b0;
            used_total--;
            rsp.status = ST_OK;
          end
        end
      end
      OP_SEARCH: begin
        if (used_total != 0 && locate_key(req.key) < TABLE_DEPTH) begin
          rsp.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    rsp.entry_count = used_total[CNT_W-1:0];
    return rsp;
  endfunction

  task automatic queue_request(logic [1:0] op, logic [KEY_WIDTH-1:0] key, bit drain);
    lphs_req_t req;
    req.opcode = op;
    req.key    = key;
    request_backlog.push_back(req);
    drain_before.push_back(drain);
  endtask

  // Request driver. A beat is taken at an edge with start high and busy low;
  // the next beat is presented in the same step, so start stays high across
  // back-to-back requests.
  always @(posedge clk) begin : drive_requests
    bit gap;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        pending_outcomes.push_back(apply_request(request));
        items_sent++;
      end
      gap = ($urandom_range(99) < 10) && !(items_sent >= 500 && items_sent < 800);
      if (request_backlog.size() != 0 && !gap &&
          !(drain_before[0] && pending_outcomes.size() != 0)) begin
        start   <= 1'b1;
        request <= request_backlog.pop_front();
        void'(drain_before.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor. Every beat with done high is checked against the oldest
  // prediction.
  always @(posedge clk) begin : check_results
    lphs_rsp_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result beat, got status %0d slot %0d count %0d",
                 $time, result.status, result.slot, result.entry_count);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, result.status);
          errors++;
        end
        if (result.slot !== want.slot) begin
          $display("%0t: slot expected %0d got %0d", $time, want.slot, result.slot);
          errors++;
        end
        if (result.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d got %0d",
                   $time, want.entry_count, result.entry_count);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL linear_probe_hash_set_core");
      $finish;
    end
  end

  initial begin : stimulus
    logic [KEY_WIDTH-1:0] inserted_keys[$];
    logic [KEY_WIDTH-1:0] key;
    logic [1:0]           op;
    int                   roll;
    int                   phase;

    // Empty table, then collisions on home slot 0, wrap from the last slot,
    // duplicates, and a hole left by a remove in the middle of a chain.
    queue_request(OP_SEARCH, 16'h0000, 1'b0);
    queue_request(OP_REMOVE, 16'h1234, 1'b0);
    queue_request(OP_UNUSED, 16'hFFFF, 1'b0);
    queue_request(OP_INSERT, 16'h0000, 1'b0);
    queue_request(OP_INSERT, 16'h0040, 1'b0);
    queue_request(OP_INSERT, 16'h0080, 1'b0);
    queue_request(OP_INSERT, 16'hFFFF, 1'b0);
    queue_request(OP_INSERT, 16'h003F, 1'b0);
    queue_request(OP_INSERT, 16'h0000, 1'b0);
    queue_request(OP_SEARCH, 16'h0080, 1'b0);
    queue_request(OP_SEARCH, 16'hFFFF, 1'b0);
    queue_request(OP_SEARCH, 16'h0005, 1'b0);
    queue_request(OP_SEARCH, 16'h00C0, 1'b0);
    queue_request(OP_REMOVE, 16'h0040, 1'b0);
    queue_request(OP_SEARCH, 16'h0080, 1'b0);
    queue_request(OP_REMOVE, 16'h0000, 1'b0);
    queue_request(OP_REMOVE, 16'h0000, 1'b0);
    queue_request(OP_REMOVE, 16'h0000, 1'b0);
    queue_request(OP_UNUSED, 16'h0000, 1'b0);
    queue_request(OP_SEARCH, 16'hAAAA, 1'b0);
    queue_request(OP_INSERT, 16'h5555, 1'b0);
    queue_request(OP_REMOVE, 16'hFFFF, 1'b0);
    queue_request(OP_INSERT, 16'h8000, 1'b0);

    // Random part in blocks that fill the table past full, mix, then drain.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      phase = (i / 150) % 3;
      roll  = $urandom_range(99);
      if (roll < 3) begin
        op = OP_UNUSED;
      end else if (phase == 0) begin
        op = (roll < 73) ? OP_INSERT : (roll < 86) ? OP_REMOVE : OP_SEARCH;
      end else if (phase == 1) begin
        op = (roll < 40) ? OP_INSERT : (roll < 70) ? OP_REMOVE : OP_SEARCH;
      end else begin
        op = (roll < 15) ? OP_INSERT : (roll < 80) ? OP_REMOVE : OP_SEARCH;
      end

      // Keys: reuse of earlier inserts, clustered homes for long chains,
      // or fully random.
      roll = $urandom_range(2);
      if (roll == 0 && inserted_keys.size() != 0) begin
        key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      end else if (roll == 1) begin
        key = (16'($urandom) & 16'hFFC0) | 16'($urandom_range(7));
      end else begin
        key = 16'($urandom);
      end

      if (op == OP_INSERT) begin
        inserted_keys.push_back(key);
        if (inserted_keys.size() > 96) begin
          void'(inserted_keys.pop_front());
        end
      end
      queue_request(op, key, (i % 350) == 0);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Let the last beat go out, then wait for every result and a tail.
    while (request_backlog.size() != 0 || start) @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS linear_probe_hash_set_core");
    end else begin
      $display("FAIL linear_probe_hash_set_core");
    end
    $finish;
  end

endmodule
